// ----- rtl/blar_pkg.sv -----
// shared types and constants for the button lockout / auto-repeat block
// no dependencies

package blar_pkg;

	localparam int NUM_BUTTONS = 6;
	localparam int FIELD_CHANNELS = 6;
	localparam int NUM_CH = (NUM_BUTTONS < FIELD_CHANNELS) ? NUM_BUTTONS : FIELD_CHANNELS;

	localparam int CNT_W = 8;
	localparam int CH_W = 3;
	localparam int IDX_W = 3;

	localparam logic [CNT_W-1:0] HOLD_MAX = 8'd255;
	localparam logic [CNT_W-1:0] LOCKOUT_RST = 8'd100;
	localparam logic [CNT_W-1:0] DELAY_RST = 8'd30;
	localparam logic [CNT_W-1:0] RELOAD_RST = 8'd25;
	localparam logic [FIELD_CHANNELS-1:0] ENABLE_RST = 6'd60;

	typedef enum logic [IDX_W-1:0] {
		REG_LOCKOUT_TICKS = 3'd0,
		REG_REPEAT_DELAY  = 3'd1,
		REG_REPEAT_RELOAD = 3'd2,
		REG_REPEAT_ENABLE = 3'd3
	} reg_idx_t;

	typedef enum logic {
		FUNC_TICK   = 1'b0,
		FUNC_CHANGE = 1'b1
	} func_t;

	typedef logic [CH_W-1:0] ch_t;
	typedef logic [NUM_CH-1:0] ch_mask_t;

	typedef struct packed {
		logic [CNT_W-1:0] lockout_ticks;
		logic [CNT_W-1:0] repeat_delay;
		logic [CNT_W-1:0] repeat_reload;
	} cfg_t;

	typedef struct packed {
		func_t func;
		logic  down;
		logic  check;
		logic  enable;
	} chan_in_t;

	function automatic ch_t first_set(input ch_mask_t mask);
		ch_t sel;
		sel = '0;
		for (int i = NUM_CH - 1; i >= 0; i--) begin
			if (mask[i]) sel = CH_W'(i);
		end
		return sel;
	endfunction

endpackage

// ----- rtl/button_lockout_auto_repeat.sv -----
// top level of the button lockout debounce with auto-repeat
// depends on blar_pkg and blar_chan
//
// usage:
//   s_axis carries one item per transfer: tuser is the kind (0 timer tick,
//   1 pin change), tdata holds the button levels and the check mask.
//   m_axis carries one event per transfer: tdata is the channel, tuser is 1
//   for a repeat and 0 for a press, tlast marks the final event of an item.
//   cfg writes one register per transfer (index, data) and is always ready;
//   write only while the block is idle.
// flow and throughput:
//   the counters update at the input transfer and the events wait in the
//   pending register; the first event of that item then moves to the output
//   register and is presented on m_axis. while m_axis_tready is high, events
//   leave one per cycle (an item has up to six), and an item with zero or one
//   event can be taken every cycle. the next item is taken in the cycle in
//   which the last event of the previous one moves to the output.
// reset: counters clear, registers take their defaults, no event pending.
// stall: while m_axis_tready is low the output holds; s_axis_tready is low
//   while more than one event is pending, or while one is pending and the
//   output register is still full.

module button_lockout_auto_repeat import blar_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [15:0]               s_axis_tdata,  // pressed[5:0], check_mask[11:6], zero
	input  logic                      s_axis_tuser,  // func
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,  // channel[2:0], zero
	output logic                      m_axis_tuser,  // is_repeat
	output logic                      m_axis_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CNT_W-1:0]          cfg_data
);

	cfg_t                      cfg_q;
	logic [FIELD_CHANNELS-1:0] enable_q;
	ch_mask_t                  pend_q, ev_mask, pend_low, pend_rest;
	logic                      pend_rep_q;
	logic                      out_valid_q, out_rep_q, out_last_q;
	ch_t                       out_ch_q;
	logic                      in_accept, load_out;
	logic [FIELD_CHANNELS-1:0] pressed, check;
	func_t                     func;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= LOCKOUT_RST;
			cfg_q.repeat_delay <= DELAY_RST;
			cfg_q.repeat_reload <= RELOAD_RST;
			enable_q <= ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= cfg_data;
				REG_REPEAT_DELAY:  cfg_q.repeat_delay <= cfg_data;
				REG_REPEAT_RELOAD: cfg_q.repeat_reload <= cfg_data;
				REG_REPEAT_ENABLE: enable_q <= cfg_data[FIELD_CHANNELS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pressed = s_axis_tdata[FIELD_CHANNELS-1:0];
	assign check = s_axis_tdata[2*FIELD_CHANNELS-1:FIELD_CHANNELS];
	assign func = func_t'(s_axis_tuser);

	assign load_out = !out_valid_q || m_axis_tready;
	assign pend_low = pend_q & (~pend_q + 1'b1);
	assign pend_rest = pend_q & (pend_q - 1'b1);
	assign s_axis_tready = (pend_q == '0) || (pend_rest == '0 && load_out);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		chan_in_t item;
		assign item.func = func;
		assign item.down = pressed[c];
		assign item.check = check[c];
		assign item.enable = enable_q[c];
		blar_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (in_accept),
			.item   (item),
			.cfg    (cfg_q),
			.fire   (ev_mask[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pend_rep_q <= 1'b0;
		end else if (in_accept) begin
			pend_q <= ev_mask;
			pend_rep_q <= (func == FUNC_TICK);
		end else if (load_out) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= (pend_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && pend_q != '0) begin
			out_ch_q <= first_set(pend_low);
			out_rep_q <= pend_rep_q;
			out_last_q <= (pend_rest == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(8-CH_W){1'b0}}, out_ch_q};
	assign m_axis_tuser = out_rep_q;
	assign m_axis_tlast = out_last_q;

	a_ready_one_left: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> ($countones(pend_q) <= 1))
		else $error("input taken while several events pending");

	a_pending_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pend_q != '0) |=> m_axis_tvalid)
		else $error("pending event not moved to output");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pend_q != '0) |=> (m_axis_tlast == ($countones($past(pend_q)) == 1)))
		else $error("tlast does not match remaining events");

	a_no_event_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && pend_q != '0) |-> (pend_rest == '0 && load_out))
		else $error("new item would overwrite pending events");

endmodule

// ----- rtl/blar_chan.sv -----
// one button channel: lockout and hold counters, fires press or repeat events
// depends on blar_pkg

module blar_chan import blar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  chan_in_t item,
	input  cfg_t     cfg,
	output logic     fire
);

	logic [CNT_W-1:0] lock_q, hold_q;
	logic [CNT_W-1:0] lock_d, hold_d, hold_inc;

	always_comb begin
		lock_d = lock_q;
		hold_d = hold_q;
		fire = 1'b0;
		hold_inc = (hold_q < HOLD_MAX) ? hold_q + 1'b1 : hold_q;
		case (item.func)
			FUNC_TICK: begin
				if (lock_q != '0) lock_d = lock_q - 1'b1;
				if (item.enable) begin
					if (item.down) begin
						if (hold_inc >= cfg.repeat_delay) begin
							fire = 1'b1;
							hold_d = cfg.repeat_reload;
						end else begin
							hold_d = hold_inc;
						end
					end else begin
						hold_d = '0;
					end
				end
			end
			FUNC_CHANGE: begin
				if (item.check && item.down && lock_q == '0) begin
					fire = 1'b1;
					lock_d = cfg.lockout_ticks;
					hold_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= '0;
			hold_q <= '0;
		end else if (accept) begin
			lock_q <= lock_d;
			hold_q <= hold_d;
		end
	end

endmodule
